// ===== hdl/b64kd_pkg.sv =====
// b64kd_pkg: shared types and constants for the base64 key decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package b64kd_pkg;

  // fixed field widths
  localparam int CHAR_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OCOUNT_W = 12;
  localparam int CAP_W    = 12;
  localparam int ACC_W    = 12;
  localparam int HELD_W   = 3;
  localparam int DIGIT_W  = 6;

  // stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXACT    = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 12'd32;
  localparam logic             EXACT_RST    = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  // digit value offsets
  localparam logic [DIGIT_W-1:0] LOWER_BASE = 6'd26;
  localparam logic [DIGIT_W-1:0] NUM_BASE   = 6'd52;
  localparam logic [DIGIT_W-1:0] PLUS_VAL   = 6'd62;
  localparam logic [DIGIT_W-1:0] SLASH_VAL  = 6'd63;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_OVER_CAP  = 2'd2,
    ST_WRONG_LEN = 2'd3
  } status_t;

  // decoder phase
  typedef enum logic [1:0] {
    PH_DECODING = 2'd0,
    PH_PADDED   = 2'd1,
    PH_FAILED   = 2'd2
  } phase_t;

  // classified character
  typedef struct packed {
    logic               is_nul;
    logic               is_pad;
    logic               is_digit;
    logic [DIGIT_W-1:0] value;
  } char_class_t;

  // one result item
  typedef struct packed {
    logic                is_done;
    logic [BYTE_W-1:0]   data_byte;
    status_t             status;
    logic [OCOUNT_W-1:0] byte_count;
  } result_t;

endpackage

// ===== hdl/b64kd_digit.sv =====
// b64kd_digit: classifies one text character (nul, pad, base64 digit and its value)
// depends on b64kd_pkg
`timescale 1ns / 1ps

module b64kd_digit
  import b64kd_pkg::*;
(
  input  logic [CHAR_W-1:0] character,
  output char_class_t       cls
);

  logic              in_upper;
  logic              in_lower;
  logic              in_num;
  logic              is_plus;
  logic              is_slash;
  logic [CHAR_W-1:0] off_upper;
  logic [CHAR_W-1:0] off_lower;
  logic [CHAR_W-1:0] off_num;

  // range checks
  assign in_upper = (character >= CH_UPPER_A) && (character <= CH_UPPER_Z);
  assign in_lower = (character >= CH_LOWER_A) && (character <= CH_LOWER_Z);
  assign in_num   = (character >= CH_ZERO) && (character <= CH_NINE);
  assign is_plus  = (character == CH_PLUS);
  assign is_slash = (character == CH_SLASH);

  assign off_upper = character - CH_UPPER_A;
  assign off_lower = character - CH_LOWER_A;
  assign off_num   = character - CH_ZERO;

  // digit value select
  always_comb begin
    cls.is_nul   = (character == CH_NUL);
    cls.is_pad   = (character == CH_PAD);
    cls.is_digit = in_upper | in_lower | in_num | is_plus | is_slash;
    priority if (in_upper) begin
      cls.value = off_upper[DIGIT_W-1:0];
    end else if (in_lower) begin
      cls.value = off_lower[DIGIT_W-1:0] + LOWER_BASE;
    end else if (in_num) begin
      cls.value = off_num[DIGIT_W-1:0] + NUM_BASE;
    end else if (is_plus) begin
      cls.value = PLUS_VAL;
    end else if (is_slash) begin
      cls.value = SLASH_VAL;
    end else begin
      cls.value = '0;
    end
  end

endmodule

// ===== hdl/b64kd_core.sv =====
// b64kd_core: decoder state, configuration registers and per-item result logic
// depends on b64kd_pkg
`timescale 1ns / 1ps

module b64kd_core
  import b64kd_pkg::*;
#(
  parameter int COUNT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  char_class_t           cls,
  output logic                  res_valid,
  output result_t               res
);

  localparam int WIDE_W = (COUNT_BITS > OCOUNT_W) ? COUNT_BITS : OCOUNT_W;

  logic [CAP_W-1:0]      capacity_r;
  logic                  exact_r;
  logic [ACC_W-1:0]      buf_r, buf_nxt;
  logic [HELD_W-1:0]     held_r, held_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  phase_t                phase_r, phase_nxt;

  logic [ACC_W-1:0]      acc;
  logic [HELD_W:0]       held_sum;
  logic [HELD_W-1:0]     held_left;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [WIDE_W-1:0]     cnt_w;
  logic [WIDE_W-1:0]     cnt_inc_w;
  logic [WIDE_W-1:0]     cap_w;
  logic                  over_cap;
  logic [BYTE_W-1:0]     out_byte;
  logic [ACC_W-1:0]      left_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
      exact_r    <= EXACT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: capacity_r <= cfg_data[CAP_W-1:0];
        REG_EXACT:    exact_r    <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // accumulator step
  assign acc       = {buf_r[ACC_W-DIGIT_W-1:0], cls.value};
  assign held_sum  = {1'b0, held_r} + (HELD_W+1)'(DIGIT_W);
  assign held_left = HELD_W'(held_sum - (HELD_W+1)'(BYTE_W));
  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_w     = WIDE_W'(cnt_r);
  assign cnt_inc_w = WIDE_W'(cnt_inc);
  assign cap_w     = WIDE_W'(capacity_r);
  assign over_cap  = (cnt_w >= cap_w) || (&cnt_r);

  // byte extraction, leftover bits are 0, 2 or 4
  always_comb begin
    out_byte  = acc[BYTE_W-1:0];
    left_mask = '0;
    unique case (held_left)
      3'd2: begin
        out_byte  = acc[BYTE_W+1:2];
        left_mask = 12'h003;
      end
      3'd4: begin
        out_byte  = acc[BYTE_W+3:4];
        left_mask = 12'h00F;
      end
      default: begin
        out_byte  = acc[BYTE_W-1:0];
        left_mask = '0;
      end
    endcase
  end

  // next state and result
  always_comb begin
    buf_nxt   = buf_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    res_valid = 1'b0;
    res       = '0;
    if (cls.is_nul) begin
      buf_nxt   = '0;
      held_nxt  = '0;
      cnt_nxt   = '0;
      phase_nxt = PH_DECODING;
      if (phase_r == PH_DECODING || phase_r == PH_PADDED) begin
        res_valid      = 1'b1;
        res.is_done    = 1'b1;
        res.status     = (exact_r && (cnt_w != cap_w)) ? ST_WRONG_LEN : ST_OK;
        res.byte_count = cnt_w[OCOUNT_W-1:0];
      end
    end else if (phase_r == PH_DECODING) begin
      if (cls.is_pad) begin
        phase_nxt = PH_PADDED;
      end else if (!cls.is_digit) begin
        phase_nxt      = PH_FAILED;
        res_valid      = 1'b1;
        res.is_done    = 1'b1;
        res.status     = ST_BAD_CHAR;
        res.byte_count = cnt_w[OCOUNT_W-1:0];
      end else if (held_sum < (HELD_W+1)'(BYTE_W)) begin
        buf_nxt  = acc;
        held_nxt = held_sum[HELD_W-1:0];
      end else if (over_cap) begin
        buf_nxt        = acc;
        held_nxt       = held_left;
        phase_nxt      = PH_FAILED;
        res_valid      = 1'b1;
        res.is_done    = 1'b1;
        res.status     = ST_OVER_CAP;
        res.byte_count = cnt_w[OCOUNT_W-1:0];
      end else begin
        buf_nxt        = acc & left_mask;
        held_nxt       = held_left;
        cnt_nxt        = cnt_inc;
        res_valid      = 1'b1;
        res.data_byte  = out_byte;
        res.status     = ST_OK;
        res.byte_count = cnt_inc_w[OCOUNT_W-1:0];
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      held_r  <= '0;
      cnt_r   <= '0;
      phase_r <= PH_DECODING;
    end else if (fire) begin
      buf_r   <= buf_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== hdl/base64_key_decoder_unit.sv =====
// base64_key_decoder_unit: top level, input register, decode core and result register
// depends on b64kd_pkg, b64kd_digit and b64kd_core
`timescale 1ns / 1ps
//
// Streaming base64 decoder (standard alphabet) for key text.
// in_*: one text character per item in in_tdata[7:0]; a zero character ends the text.
// out_*: at most one result item per input item. out_tuser is 1 for the final
//   outcome of a text (status, total count) and 0 for a decoded data byte.
// cfg_*: register writes, index 0 capacity, index 1 exact-length check; cfg_ready
//   is always high, writes are meant for an idle block.
// Timing: an accepted item waits in the input register until the result register is
//   free; its result is then registered there and shown on out_*.
// Throughput: one item per cycle while the receiver takes results, set by the single
//   decode step between the input register and the result register.
// Reset (rst_n low, synchronous): both registers empty, decoder at a fresh text,
//   capacity 32, exact-length check on.
// When the receiver stalls the result register holds; the input register still
//   takes one more item, then in_tready drops until the result is taken.
//
module base64_key_decoder_unit
  import b64kd_pkg::*;
#(
  parameter int COUNT_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] character
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [9:8] status,
                                             // [21:10] byte_count, [23:22] zero
  output logic                   out_tuser,  // [0] is_done
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  logic              advance;
  logic              in_fire;
  char_class_t       cls;
  logic              res_valid;
  result_t           res;

  assign cfg_ready = 1'b1;

  // handshake control
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? res_valid : (out_tready ? 1'b0 : out_valid_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_tdata[CHAR_W-1:0];
    end
  end

  b64kd_digit u_digit (
    .character (s1_char_r),
    .cls       (cls)
  );

  b64kd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  // result packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.is_done;
  assign out_tdata  = {2'b00, out_res_r.byte_count, out_res_r.status, out_res_r.data_byte};

endmodule

// ===== hdl/b64kd_checker.sv =====
// b64kd_checker: port-level assertions for base64_key_decoder_unit, with its bind
// depends on b64kd_pkg and base64_key_decoder_unit
`timescale 1ns / 1ps

module b64kd_checker
  import b64kd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // data byte items always carry status ok
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[9:8] == ST_OK)
    else $error("data byte item with failure status");

  // final outcome items carry a zero data byte
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == '0)
    else $error("final outcome item with nonzero data byte");

  // input side never stalls while the result register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with free result register");

endmodule

bind base64_key_decoder_unit b64kd_checker u_b64kd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/base64_key_decoder_unit_test.sv =====
// base64_key_decoder_unit_test: self-checking testbench for the base64 key decoder
// drives text characters and register writes, predicts every result item and compares
// depends on b64kd_pkg and base64_key_decoder_unit
`timescale 1ns / 1ps

module base64_key_decoder_unit_test;
  import b64kd_pkg::*;

  localparam int          COUNT_BITS   = 12;
  localparam logic [11:0] COUNT_MAX    = 12'hFFF;
  localparam int          RANDOM_ITEMS = 1250;
  localparam int          DIRECTED_N   = 29;
  localparam int          SETTLE       = 4;
  localparam int          DRAIN        = 8;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          CALM_FROM    = 700;
  localparam int          CALM_TO      = 900;
  localparam int          STATUS_LO    = BYTE_W;
  localparam int          COUNT_LO     = BYTE_W + STATUS_W;
  localparam int          PAD_LO       = BYTE_W + STATUS_W + OCOUNT_W;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] character
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] data_byte, [9:8] status, [21:10] byte_count
  logic                   out_tuser;  // [0] is_done
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // one row of the directed script: a register write or a character
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    bit                    pinned;
    bit                    pinned_any;
    result_t               pinned_res;
  } row_t;

  // decoder model state and register copies
  logic [ACC_W-1:0]    acc_bits;
  logic [HELD_W-1:0]   acc_held;
  logic [11:0]         text_bytes;
  phase_t              text_phase;
  logic [CAP_W-1:0]    cap_reg;
  logic                exact_reg;

  result_t     pending_results[$];
  int unsigned chars_sent;
  int unsigned mismatches;
  row_t        script [DIRECTED_N];

  base64_key_decoder_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // stretch of the run with no idling on either side
  function automatic bit calm();
    return chars_sent >= CALM_FROM && chars_sent < CALM_TO;
  endfunction

  // six-bit value of a base64 digit, -1 for anything else
  function automatic int digit_of(input logic [7:0] ch);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return int'(ch - CH_UPPER_A);
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) return int'(ch - CH_LOWER_A) + int'(LOWER_BASE);
    if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO) + int'(NUM_BASE);
    if (ch == CH_PLUS) return int'(PLUS_VAL);
    if (ch == CH_SLASH) return int'(SLASH_VAL);
    return -1;
  endfunction

  // character that carries a random six-bit digit
  function automatic logic [7:0] random_digit();
    int unsigned v;
    v = $urandom_range(0, 63);
    if (v < LOWER_BASE) return CH_UPPER_A + 8'(v);
    if (v < NUM_BASE) return CH_LOWER_A + 8'(v - LOWER_BASE);
    if (v < PLUS_VAL) return CH_ZERO + 8'(v - NUM_BASE);
    if (v == PLUS_VAL) return CH_PLUS;
    return CH_SLASH;
  endfunction

  // advance the decoder model by one character, return the result it causes
  function automatic void decode_char(input logic [7:0] ch, output bit produced,
                                      output result_t res);
    int          digit;
    int unsigned held_sum;
    produced = 1'b0;
    res      = '0;
    digit    = digit_of(ch);
    if (ch == CH_NUL) begin
      if (text_phase == PH_DECODING || text_phase == PH_PADDED) begin
        produced       = 1'b1;
        res.is_done    = 1'b1;
        res.byte_count = text_bytes;
        res.status     = (exact_reg && text_bytes != cap_reg) ? ST_WRONG_LEN : ST_OK;
      end
      acc_bits   = '0;
      acc_held   = '0;
      text_bytes = '0;
      text_phase = PH_DECODING;
    end else if (text_phase != PH_DECODING) begin
      // padded or failed text swallows everything up to the terminator
    end else if (ch == CH_PAD) begin
      text_phase = PH_PADDED;
    end else if (digit < 0) begin
      text_phase     = PH_FAILED;
      produced       = 1'b1;
      res.is_done    = 1'b1;
      res.status     = ST_BAD_CHAR;
      res.byte_count = text_bytes;
    end else begin
      acc_bits = {acc_bits[5:0], 6'(digit)};
      held_sum = acc_held + 6;
      if (held_sum < 8) begin
        acc_held = HELD_W'(held_sum);
      end else begin
        acc_held = HELD_W'(held_sum - 8);
        produced = 1'b1;
        if (text_bytes >= cap_reg || text_bytes >= COUNT_MAX) begin
          text_phase     = PH_FAILED;
          res.is_done    = 1'b1;
          res.status     = ST_OVER_CAP;
          res.byte_count = text_bytes;
        end else begin
          res.data_byte  = 8'(acc_bits >> acc_held);
          acc_bits       = acc_bits & ((12'd1 << acc_held) - 12'd1);
          text_bytes     = text_bytes + 12'd1;
          res.byte_count = text_bytes;
        end
      end
    end
  endfunction

  // script row builders
  function automatic row_t char_row(input logic [7:0] ch);
    row_t r;
    r     = '{default: '0};
    r.val = CFG_DATA_W'(ch);
    return r;
  endfunction

  function automatic row_t pin_row(input logic [7:0] ch, input bit any, input status_t st,
                                   input logic [11:0] cnt);
    row_t r;
    r                       = char_row(ch);
    r.pinned                = 1'b1;
    r.pinned_any            = any;
    r.pinned_res            = '0;
    r.pinned_res.is_done    = 1'b1;
    r.pinned_res.status     = st;
    r.pinned_res.byte_count = cnt;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40)
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // offer one character, wait for it to be taken, then record what it should cause
  task automatic send_char(input logic [7:0] ch, input bit pinned = 1'b0,
                           input bit pinned_any = 1'b0, input result_t pinned_res = '0);
    bit      produced;
    result_t res;
    if (!calm() && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    decode_char(ch, produced, res);
    if (pinned) begin
      produced = pinned_any;
      res      = pinned_res;
    end
    if (produced) pending_results.push_back(res);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAPACITY: cap_reg = val;
      REG_EXACT:    exact_reg = val[0];
      default: ;
    endcase
  endtask

  // one text: mostly well-formed base64, some broken, some noise; always terminated
  task automatic send_text();
    int unsigned roll, n_bytes, n_digits, cut, top;
    roll     = $urandom_range(99);
    top      = (cap_reg > 40) ? 40 : cap_reg;
    n_bytes  = (cap_reg <= 40 && $urandom_range(1)) ? cap_reg : $urandom_range(0, top + 3);
    n_digits = (4 * n_bytes + 2) / 3;
    if (roll < 15) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
    end else begin
      cut = (roll < 30) ? $urandom_range(0, n_digits) : n_digits + 1;
      for (int i = 0; i < n_digits; i++) begin
        if (i == cut) send_char(8'($urandom_range(1, 255)));
        send_char(random_digit());
      end
      if (cut == n_digits) send_char(8'($urandom_range(1, 255)));
      if (roll >= 30) begin
        repeat ((4 - n_digits % 4) % 4) send_char(CH_PAD);
        if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(1, 255)));
      end
    end
    send_char(CH_NUL);
  endtask

  // result receiver: random stalls, one long hold-off, a calm stretch
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && chars_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= calm() || $urandom_range(99) >= 14;
      end
      @(posedge clk);
    end
  end

  // compare each taken result item with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.is_done) report_mismatch("is_done", out_tuser, want.is_done);
        if (out_tdata[BYTE_W-1:0] !== want.data_byte)
          report_mismatch("data_byte", out_tdata[BYTE_W-1:0], want.data_byte);
        if (out_tdata[STATUS_LO +: STATUS_W] !== want.status)
          report_mismatch("status", out_tdata[STATUS_LO +: STATUS_W], want.status);
        if (out_tdata[COUNT_LO +: OCOUNT_W] !== want.byte_count)
          report_mismatch("byte_count", out_tdata[COUNT_LO +: OCOUNT_W], want.byte_count);
        if (out_tdata[OUT_TDATA_W-1:PAD_LO] !== '0)
          report_mismatch("tdata fill bits", out_tdata[OUT_TDATA_W-1:PAD_LO], 0);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("base64_key_decoder_unit verification failed");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    int unsigned pick;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_CAPACITY;
    cfg_data   <= '0;
    chars_sent = 0;
    mismatches = 0;
    cap_reg    = CAPACITY_RST;
    exact_reg  = EXACT_RST;
    acc_bits   = '0;
    acc_held   = '0;
    text_bytes = '0;
    text_phase = PH_DECODING;

    script = '{
      // empty text right after reset
      pin_row(CH_NUL, 1'b1, ST_WRONG_LEN, 12'd0),
      // "TWFu" then padding, a stray character after it, terminator
      char_row("T"), char_row("W"), char_row("F"), char_row("u"),
      char_row(CH_PAD), char_row("!"),
      pin_row(CH_NUL, 1'b1, ST_WRONG_LEN, 12'd3),
      // bad character, ignored tail, silent terminator
      pin_row("!", 1'b1, ST_BAD_CHAR, 12'd0), char_row("Q"),
      pin_row(CH_NUL, 1'b0, ST_OK, 12'd0),
      // alphabet extremes, then a top-bit character
      char_row(CH_PLUS), char_row(CH_SLASH), char_row(CH_LOWER_Z), char_row(CH_NINE),
      pin_row(8'hFF, 1'b1, ST_BAD_CHAR, 12'd3),
      pin_row(CH_NUL, 1'b0, ST_OK, 12'd0),
      // one byte allowed, the second overflows
      cfg_row(REG_CAPACITY, 12'd1), cfg_row(REG_EXACT, 12'd0),
      char_row(CH_UPPER_A), char_row(CH_UPPER_Z),
      pin_row(CH_LOWER_A, 1'b1, ST_OVER_CAP, 12'd1),
      pin_row(CH_NUL, 1'b0, ST_OK, 12'd0),
      // zero capacity: empty text is exact, first byte overflows
      cfg_row(REG_CAPACITY, 12'd0), cfg_row(REG_EXACT, 12'd1),
      pin_row(CH_NUL, 1'b1, ST_OK, 12'd0),
      char_row(CH_ZERO),
      pin_row(CH_NINE, 1'b1, ST_OVER_CAP, 12'd0),
      pin_row(CH_NUL, 1'b0, ST_OK, 12'd0)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed script
    foreach (script[i]) begin
      if (script[i].is_cfg)
        write_reg(script[i].idx, script[i].val);
      else
        send_char(script[i].val[7:0], script[i].pinned, script[i].pinned_any,
                  script[i].pinned_res);
    end

    // random phases: new register settings, then a batch of texts
    while (chars_sent < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(9);
      case (pick)
        0:       write_reg(REG_CAPACITY, 12'd0);
        1:       write_reg(REG_CAPACITY, 12'hFFF);
        2:       write_reg(REG_CAPACITY, 12'($urandom_range(0, 4095)));
        default: write_reg(REG_CAPACITY, 12'($urandom_range(1, 40)));
      endcase
      write_reg(REG_EXACT, 12'($urandom_range(1)));
      repeat ($urandom_range(3, 8)) send_text();
    end

    // drain and decide
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("base64_key_decoder_unit verification clean");
    else
      $display("base64_key_decoder_unit verification failed");
    $finish;
  end

endmodule
